// File: sv/mcpq_pkg.sv
// ----------------------------------------------------------------------------
// mcpq_pkg: shared types and codes for the multi-class priority queue
// Beat layouts, command and status codes, and the entry held by each cell.
// ----------------------------------------------------------------------------
package mcpq_pkg;

    localparam int PRIO_W            = 8;
    localparam int TICKET_W          = 16;
    localparam int NUM_QUEUES_DEF    = 3;
    localparam int QUEUE_DEPTH_DEF   = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_SERVED   = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [1:0]        queue_index;
        logic [PRIO_W-1:0] priority_level;
    } cmd_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [TICKET_W-1:0] ticket_number;
    } rsp_t;

    typedef struct packed {
        logic                valid;
        logic [PRIO_W-1:0]   prio;
        logic [TICKET_W-1:0] ticket;
    } entry_t;

    // broadcast to every cell of one queue
    typedef struct packed {
        logic   ins;
        logic   rem;
        logic   clr;
        entry_t fresh;
    } cell_cmd_t;

endpackage

// File: sv/mcpq_cell.sv
// ----------------------------------------------------------------------------
// mcpq_cell: one slot of a sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its
// better neighbour's; on remove it takes its worse neighbour's entry.
// ----------------------------------------------------------------------------
module mcpq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  mcpq_pkg::cell_cmd_t cmd,
    input  mcpq_pkg::entry_t   prev_ent,
    input  logic               prev_beats,
    input  mcpq_pkg::entry_t   next_ent,
    output mcpq_pkg::entry_t   ent,
    output logic               beats
);
    import mcpq_pkg::*;

    logic                valid_reg, valid_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [TICKET_W-1:0] ticket_reg, ticket_next;

    // the new entry is always the youngest, so equal priority never wins
    assign beats = !valid_reg || (cmd.fresh.prio > prio_reg);

    always_comb
    begin
        valid_next  = valid_reg;
        prio_next   = prio_reg;
        ticket_next = ticket_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.ins)
        begin
            if (prev_beats)
            begin
                valid_next  = prev_ent.valid;
                prio_next   = prev_ent.prio;
                ticket_next = prev_ent.ticket;
            end
            else if (beats)
            begin
                valid_next  = cmd.fresh.valid;
                prio_next   = cmd.fresh.prio;
                ticket_next = cmd.fresh.ticket;
            end
        end
        else if (cmd.rem)
        begin
            valid_next  = next_ent.valid;
            prio_next   = next_ent.prio;
            ticket_next = next_ent.ticket;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg   <= prio_next;
        ticket_reg <= ticket_next;
    end

    assign ent = '{valid: valid_reg, prio: prio_reg, ticket: ticket_reg};

endmodule

// File: sv/mcpq_chain.sv
// ----------------------------------------------------------------------------
// mcpq_chain: one priority queue as a row of sorted cells
// Cell zero holds the entry to serve next; the last cell shows fullness.
// ----------------------------------------------------------------------------
module mcpq_chain #(
    parameter int QUEUE_DEPTH = mcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcpq_pkg::cell_cmd_t cmd,
    output mcpq_pkg::entry_t    head,
    output logic                full
);
    import mcpq_pkg::*;

    entry_t ent   [QUEUE_DEPTH];
    logic   beats [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t prev_ent, next_ent;
        logic   prev_beats;

        if (i == 0)
        begin : g_first
            assign prev_ent   = '0;
            assign prev_beats = 1'b0;
        end
        else
        begin : g_mid
            assign prev_ent   = ent[i-1];
            assign prev_beats = beats[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_ent = '0;
        end
        else
        begin : g_inner
            assign next_ent = ent[i+1];
        end

        mcpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_ent   (prev_ent),
            .prev_beats (prev_beats),
            .next_ent   (next_ent),
            .ent        (ent[i]),
            .beats      (beats[i])
        );
    end

    assign head = ent[0];
    assign full = ent[QUEUE_DEPTH-1].valid;

endmodule

// File: sv/multi_class_priority_queue.sv
// ----------------------------------------------------------------------------
// multi_class_priority_queue: stable priority queues with a shared ticket
// Several sorted cell chains served by one ticket counter; remove returns
// the highest priority, oldest ticket of the addressed queue.
// ----------------------------------------------------------------------------
//  channel | signals                    | beat
//  cmd     | cmd_valid, cmd_stall, cmd  | opcode, queue_index, priority_level
//  rsp     | rsp_valid, rsp_stall, rsp  | status, ticket_number
//
//  Each command settles in the cycle it is taken: every cell of the queue
//  compares and shifts at once. The result is registered in the cycle
//  after. Commands are held off only while a result waits under
//  rsp_stall. Reset empties every queue and zeroes the ticket counter.
// ----------------------------------------------------------------------------
module multi_class_priority_queue #(
    parameter int NUM_QUEUES  = mcpq_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = mcpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mcpq_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mcpq_pkg::rsp_t rsp
);
    import mcpq_pkg::*;

    logic                accept;
    logic                is_ins, is_rem, is_clr;
    logic [NUM_QUEUES-1:0] sel;
    logic                any_sel;
    entry_t              head [NUM_QUEUES];
    logic                full [NUM_QUEUES];
    entry_t              head_sel;
    logic                full_sel;
    logic                exhausted;
    logic                drop;
    entry_t              fresh;

    logic [TICKET_W-1:0] count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_ins    = accept && (cmd.opcode == OP_INSERT);
    assign is_rem    = accept && (cmd.opcode == OP_REMOVE);
    assign is_clr    = accept && (cmd.opcode == OP_CLEAR);
    assign exhausted = (count_reg == {TICKET_W{1'b1}});

    always_comb
    begin
        head_sel = '0;
        full_sel = 1'b0;
        for (int k = 0; k < NUM_QUEUES; k++)
        begin
            if (sel[k])
            begin
                head_sel = head[k];
                full_sel = full[k];
            end
        end
    end

    assign any_sel = |sel;
    assign drop    = full_sel || exhausted;
    assign fresh   = '{valid: 1'b1, prio: cmd.priority_level,
                       ticket: count_reg + TICKET_W'(1)};

    for (genvar k = 0; k < NUM_QUEUES; k++)
    begin : g_queue
        cell_cmd_t qcmd;

        // a queue index beyond the last queue selects nothing
        assign sel[k] = (32'(cmd.queue_index) == k);

        assign qcmd.ins   = is_ins && sel[k] && !drop;
        assign qcmd.rem   = is_rem && sel[k];
        assign qcmd.clr   = is_clr;
        assign qcmd.fresh = fresh;

        mcpq_chain #(
            .QUEUE_DEPTH (QUEUE_DEPTH)
        ) u_chain (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (qcmd),
            .head  (head[k]),
            .full  (full[k])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (is_clr)
        begin
            count_next = '0;
        end
        else if (is_ins && any_sel)
        begin
            if (drop)
            begin
                rsp_valid_next         = 1'b1;
                rsp_next.status        = ST_OVERFLOW;
                rsp_next.ticket_number = '0;
            end
            else
            begin
                count_next = fresh.ticket;
            end
        end
        else if (is_rem && any_sel)
        begin
            rsp_valid_next = 1'b1;
            if (head_sel.valid)
            begin
                rsp_next.status        = ST_SERVED;
                rsp_next.ticket_number = head_sel.ticket;
            end
            else
            begin
                rsp_next.status        = ST_EMPTY;
                rsp_next.ticket_number = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: sv/mcpq_checker.sv
// ----------------------------------------------------------------------------
// mcpq_checker: port-level checks for the multi-class priority queue
// Watches both channels over time; bound onto the top level below.
// ----------------------------------------------------------------------------
module mcpq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_stall,
    input mcpq_pkg::cmd_t cmd,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input mcpq_pkg::rsp_t rsp
);
    import mcpq_pkg::*;

    // hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result beat changed");

    // commands wait only behind a stalled result
    a_cmd_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("command stalled without a waiting result");

    // only a served beat carries a ticket
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_SERVED && rsp.ticket_number != '0) ||
                      ((rsp.status == ST_EMPTY || rsp.status == ST_OVERFLOW) &&
                       rsp.ticket_number == '0))
        else $error("bad status or ticket in result beat");

    // a clear gives no result
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.opcode == OP_CLEAR |=> !rsp_valid)
        else $error("clear produced a result");

endmodule

bind multi_class_priority_queue mcpq_checker u_mcpq_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: multi-class priority queue
// Drives insert, remove and clear beats through the cmd channel under
// several idle and stall patterns. A local model of the three queues and the
// shared ticket counter predicts each served ticket, empty report and
// overflow, and every rsp beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    import mcpq_pkg::*;

    localparam int          NQ          = NUM_QUEUES_DEF;
    localparam int          DEPTH       = QUEUE_DEPTH_DEF;
    localparam logic [15:0] TICKET_LAST = 16'hFFFF;
    localparam logic [1:0]  OP_UNDEF    = 2'd3;
    localparam logic [1:0]  Q_OUTSIDE   = 2'd3;
    localparam int          TAIL        = 8;
    localparam int          CYCLE_LIMIT = 1000000;

    logic clk        = 1'b0;
    logic rst_n      = 1'b0;
    logic cmd_valid  = 1'b0;
    logic cmd_stall;
    cmd_t cmd        = '0;
    logic rsp_valid;
    logic rsp_stall  = 1'b0;
    rsp_t rsp;

    cmd_t        cmd_backlog[$];
    rsp_t        predicted_rsp[$];
    logic        cmd_taken = 1'b0;
    int unsigned cmds_queued   = 0;
    int unsigned cmds_accepted = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    // model of the queue contents and the ticket counter
    bit          slot_held  [NQ][DEPTH];
    logic [7:0]  slot_prio  [NQ][DEPTH];
    logic [15:0] slot_ticket[NQ][DEPTH];
    logic [15:0] last_ticket = '0;

    multi_class_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic empty_all_queues();
        for (int q = 0; q < NQ; q++)
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_held[q][i]   = 1'b0;
                slot_prio[q][i]   = '0;
                slot_ticket[q][i] = '0;
            end
        last_ticket = '0;
    endtask

    // apply one accepted command to the model and queue its result, if any
    task automatic apply_command(input cmd_t c);
        int   q;
        int   pick;
        rsp_t r;
        q    = int'(c.queue_index);
        pick = -1;
        r    = '0;
        if (c.opcode == OP_CLEAR)
            empty_all_queues();
        else if ((c.opcode == OP_INSERT || c.opcode == OP_REMOVE) && q < NQ)
        begin
            if (c.opcode == OP_INSERT)
            begin
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!slot_held[q][i])
                        pick = i;
                if (pick < 0 || last_ticket == TICKET_LAST)
                begin
                    r.status = ST_OVERFLOW;
                    predicted_rsp.push_back(r);
                end
                else
                begin
                    last_ticket             = last_ticket + 16'd1;
                    slot_held[q][pick]      = 1'b1;
                    slot_prio[q][pick]      = c.priority_level;
                    slot_ticket[q][pick]    = last_ticket;
                end
            end
            else
            begin
                // highest priority first, oldest ticket among equals
                for (int i = 0; i < DEPTH; i++)
                    if (slot_held[q][i] && (pick < 0
                        || slot_prio[q][i] > slot_prio[q][pick]
                        || (slot_prio[q][i] == slot_prio[q][pick]
                            && slot_ticket[q][i] < slot_ticket[q][pick])))
                        pick = i;
                if (pick < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status           = ST_SERVED;
                    r.ticket_number    = slot_ticket[q][pick];
                    slot_held[q][pick] = 1'b0;
                end
                predicted_rsp.push_back(r);
            end
        end
    endtask

    // driver: move on to the next beat only once the current one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_taken)
        begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                cmd       <= cmd_backlog.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // monitor: check the rsp beat first, then predict from the cmd beat
    always @(posedge clk)
    begin
        rsp_t want;
        cycle_count++;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsp.size() == 0)
                begin
                    $error("rsp beat with no prediction: status %0d ticket %0d",
                           rsp.status, rsp.ticket_number);
                    mismatches++;
                end
                else
                begin
                    want = predicted_rsp.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.ticket_number !== want.ticket_number)
                    begin
                        $error("ticket_number: expected %0d, got %0d",
                               want.ticket_number, rsp.ticket_number);
                        mismatches++;
                    end
                end
            end
            cmd_taken <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                apply_command(cmd);
                cmds_accepted++;
            end
        end
    end

    function automatic logic [7:0] pick_prio();
        // half the time a narrow range, so equal priorities are common
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(3));
        return 8'($urandom);
    endfunction

    task automatic send(input logic [1:0] op, input logic [1:0] q, input logic [7:0] p);
        cmd_t c;
        c.opcode         = op;
        c.queue_index    = q;
        c.priority_level = p;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // hold the sender until every prediction has been met
    task automatic wait_drained();
        while (cmds_accepted != cmds_queued || predicted_rsp.size() != 0)
            @(negedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        int          done;
        int unsigned choice;
        logic [1:0]  q;
        done = 0;
        while (done < count)
        begin
            choice = $urandom_range(99);
            q      = 2'($urandom_range(NQ - 1));
            if (choice < 4)
                send($urandom_range(1) ? OP_INSERT : OP_REMOVE, Q_OUTSIDE, 8'($urandom));
            else if (choice < 7)
                send(OP_UNDEF, 2'($urandom_range(3)), 8'($urandom));
            else if (choice < 9)
            begin
                send(OP_CLEAR, 2'($urandom_range(3)), 8'($urandom));
                done++;
            end
            else if (choice < 14)
            begin
                // fill one queue past its depth
                repeat (DEPTH + 1 + $urandom_range(3))
                begin
                    send(OP_INSERT, q, pick_prio());
                    done++;
                end
            end
            else if (choice < 18)
            begin
                // drain one queue past empty
                repeat (DEPTH + 1)
                begin
                    send(OP_REMOVE, q, 8'($urandom));
                    done++;
                end
            end
            else if (choice < 58)
            begin
                send(OP_INSERT, q, pick_prio());
                done++;
            end
            else
            begin
                send(OP_REMOVE, q, 8'($urandom));
                done++;
            end
        end
    endtask

    initial
    begin
        empty_all_queues();

        // ordering by priority, then by age
        send(OP_REMOVE, 2'd0, 8'd0);
        send(OP_INSERT, 2'd0, 8'd0);
        send(OP_INSERT, 2'd0, 8'd255);
        send(OP_INSERT, 2'd0, 8'd255);
        send(OP_INSERT, 2'd0, 8'd128);
        send(OP_INSERT, 2'd1, 8'd7);
        send(OP_INSERT, 2'd1, 8'd7);
        send(OP_REMOVE, 2'd0, 8'd0);
        send(OP_REMOVE, 2'd0, 8'd0);
        send(OP_REMOVE, 2'd0, 8'd0);
        send(OP_REMOVE, 2'd0, 8'd0);
        send(OP_REMOVE, 2'd0, 8'd0);
        send(OP_REMOVE, 2'd1, 8'd0);
        // queue outside the range and the undefined opcode are ignored
        send(OP_INSERT, Q_OUTSIDE, 8'd200);
        send(OP_REMOVE, Q_OUTSIDE, 8'd0);
        send(OP_UNDEF,  2'd2, 8'd99);
        send(OP_CLEAR,  2'd0, 8'd0);
        send(OP_REMOVE, 2'd1, 8'd0);
        send(OP_INSERT, 2'd2, 8'd1);
        send(OP_REMOVE, 2'd2, 8'd0);
        send(OP_REMOVE, 2'd2, 8'd0);
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        wait_drained();

        // equal priorities in one queue, then a clear restarts the tickets
        send(OP_CLEAR, 2'd0, 8'd0);
        send(OP_INSERT, 2'd1, 8'd9);
        send(OP_INSERT, 2'd1, 8'd9);
        send(OP_INSERT, 2'd2, 8'd0);
        send(OP_REMOVE, 2'd1, 8'd0);
        send(OP_REMOVE, 2'd1, 8'd0);
        send(OP_CLEAR, 2'd0, 8'd0);
        send(OP_INSERT, 2'd0, 8'd3);
        send(OP_REMOVE, 2'd0, 8'd0);
        wait_drained();

        send_random(135);
        wait_drained();

        sender_idle_pct    = 84;
        receiver_stall_pct = 0;
        send_random(135);
        wait_drained();

        sender_idle_pct    = 0;
        receiver_stall_pct = 84;
        send_random(135);
        wait_drained();

        sender_idle_pct    = 19;
        receiver_stall_pct = 19;
        send_random(135);
        wait_drained();

        @(negedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/mcpq_pkg.sv
sv/mcpq_cell.sv
sv/mcpq_chain.sv
sv/multi_class_priority_queue.sv
sv/mcpq_checker.sv
verif/testbench.sv
